@@ hw/rtl/anlp_pkg.sv @@
// Shared types and constants for the Annex B to length-prefix converter.
// Used by anlp_front, anlp_queue, anlp_back and the top level.
package anlp_pkg;

   localparam int LENGTH_BITS = 24;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_DROPPED  = 2'd2;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;

   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

   typedef struct packed {
      logic [7:0]             out_byte;
      logic [1:0]             kind;
      logic [LENGTH_BITS-1:0] nal_length;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } push_type;

   typedef struct packed {
      logic       inside_unit;
      logic [1:0] fill;
   } front_status_type;

endpackage

@@ hw/rtl/anlp_front.sv @@
// Front part: accepts stream bytes, tracks the lookahead window and, inside a unit,
// turns bytes into payload/complete/dropped results. Depends on anlp_pkg.
module anlp_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 data_byte,
   input  logic                       end_of_stream,
   output anlp_pkg::push_type         push,
   output anlp_pkg::front_status_type status
);
   import anlp_pkg::*;

   logic [7:0]             look_ff [3];
   logic [7:0]             look_in [3];
   logic [1:0]             fill_ff, fill_in;
   logic                   inside_ff, inside_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   start_code;

   assign start_code = (fill_ff == 2'd3) && (look_ff[0] == BYTE_ZERO) &&
                       (look_ff[1] == BYTE_ZERO) && (look_ff[2] == BYTE_ZERO) &&
                       (data_byte == BYTE_ONE);

   always_comb begin
      look_in   = look_ff;
      fill_in   = fill_ff;
      inside_in = inside_ff;
      count_in  = count_ff;
      push      = '0;
      if (accept) begin
         priority if (end_of_stream) begin
            fill_in   = 2'd0;
            inside_in = 1'b0;
            count_in  = '0;
            push.valid       = inside_ff;
            push.result.kind = KIND_DROPPED;
         end else if (start_code) begin
            fill_in   = 2'd0;
            inside_in = 1'b1;
            count_in  = '0;
            push.valid             = inside_ff;
            push.result.kind       = KIND_COMPLETE;
            push.result.nal_length = count_ff;
         end else if (fill_ff != 2'd3) begin
            look_in[fill_ff] = data_byte;
            fill_in          = fill_ff + 2'd1;
         end else begin
            // window full: shift, oldest byte leaves as payload
            look_in[0] = look_ff[1];
            look_in[1] = look_ff[2];
            look_in[2] = data_byte;
            push.valid           = inside_ff;
            push.result.kind     = KIND_PAYLOAD;
            push.result.out_byte = look_ff[0];
            if (inside_ff && (count_ff != LENGTH_MAX)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      look_ff <= look_in;
      if (reset) begin
         fill_ff   <= 2'd0;
         inside_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         fill_ff   <= fill_in;
         inside_ff <= inside_in;
         count_ff  <= count_in;
      end
   end

   assign status.inside_unit = inside_ff;
   assign status.fill        = fill_ff;

endmodule

@@ hw/rtl/anlp_queue.sv @@
// Short result queue between front and back parts.
// Depends on anlp_pkg.
module anlp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  anlp_pkg::push_type   push,
   input  logic                 pop,
   output anlp_pkg::result_type head,
   output logic                 not_empty,
   output logic                 full
);
   import anlp_pkg::*;

   result_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/anlp_back.sv @@
// Back part: output register that drains the queue onto the result channel.
// Depends on anlp_pkg.
module anlp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  anlp_pkg::result_type head,
   input  logic                 head_valid,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_stall,
   output anlp_pkg::result_type out_result
);
   import anlp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // load when the output slot is empty or is being taken this cycle
   assign pop      = head_valid && (!valid_ff || !out_stall);
   assign valid_in = pop || (valid_ff && out_stall);

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = data_ff;

endmodule

@@ hw/rtl/annexb_nal_to_length_prefix.sv @@
// Top level of the Annex B to length-prefix converter: front classifier,
// result queue and output stage. Depends on anlp_pkg, anlp_front, anlp_queue, anlp_back.
//
//   channel  direction  ports                                   handshake
//   req      in         req_data_byte, req_end_of_stream        req_valid / req_stall
//   rsp      out        rsp_out_byte, rsp_kind, rsp_nal_length  rsp_valid / rsp_stall
//
// One item per clock is accepted while req_stall is low; each item is classified in
// the cycle it is accepted and any result enters a two-entry queue.
// A result reaches rsp through a queue write and then an output register load.
// Reset (synchronous, active high) empties the lookahead, queue and output.
// req_stall rises only while the queue is full, i.e. after rsp has stalled.
module annexb_nal_to_length_prefix (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_end_of_stream,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_out_byte,
   output logic [1:0]                           rsp_kind,
   output logic [anlp_pkg::LENGTH_BITS-1:0]     rsp_nal_length
);
   import anlp_pkg::*;

   logic             accept;
   push_type         push;
   front_status_type front_status;
   result_type       head;
   result_type       out_result;
   logic             head_valid;
   logic             queue_full;
   logic             pop;

   // hold off new items only while the queue cannot take a result
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   anlp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_stream (req_end_of_stream),
      .push          (push),
      .status        (front_status)
   );

   anlp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (head_valid),
      .full      (queue_full)
   );

   anlp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (out_result)
   );

   assign rsp_out_byte   = out_result.out_byte;
   assign rsp_kind       = out_result.kind;
   assign rsp_nal_length = out_result.nal_length;

   // end of stream always leaves the block outside any unit with an empty window
   a_eos_clears : assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_stream |=> !front_status.inside_unit && front_status.fill == 2'd0)
      else $error("end of stream did not clear front state");

   // a start code completion restarts the window
   a_start_code_empties : assert property (@(posedge clock) disable iff (reset)
      push.valid && push.result.kind == KIND_COMPLETE |=> front_status.fill == 2'd0
         && front_status.inside_unit)
      else $error("start code did not empty the lookahead");

   // results never get pushed into a full queue
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push.valid)
      else $error("result pushed into full queue");

   // non-payload results carry a zero byte, non-complete ones a zero length
   a_result_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_PAYLOAD || rsp_out_byte == BYTE_ZERO) &&
         (rsp_kind == KIND_COMPLETE || rsp_nal_length == '0))
      else $error("malformed result item");

endmodule
